// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file sep_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent sequence.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

`endif

// ===== rtl/sep_pkg.sv =====
// Shared types, constants and saturating helpers of the shock pressure pipeline.
package sep_pkg;

    localparam int FRAC_BITS = 32;

    localparam logic [63:0] FX_ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DENSITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_SPEED = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUG_SLOPE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_COEFF  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VISC_QUAD   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VISC_LIN    = 8'd7;

    localparam logic [16:0] DMG_ONE = 17'd65536;

    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS  = 128;
    localparam int DIV_LAT    = DIV_STEPS + 2;
    localparam int MUL_LAT    = 4;
    localparam int NUM_OPS    = 15;
    localparam int NUM_DIV    = 3;
    localparam int NUM_MUL    = NUM_OPS - NUM_DIV;
    localparam logic [NUM_OPS-1:0] OP_IS_DIV = 15'b000_0000_1100_0001;
    localparam int LATENCY = SQRT_STEPS + NUM_DIV * DIV_LAT + NUM_MUL * MUL_LAT + 2;

    typedef struct packed {
        logic [62:0]        density;
        logic signed [63:0] temperature;
        logic [16:0]        damage;
        logic signed [63:0] rate_xx;
        logic signed [63:0] rate_yy;
        logic signed [63:0] rate_zz;
        logic [62:0]        volume_ratio;
    } in_t;

    typedef struct packed {
        logic signed [63:0] pressure;
        logic [62:0]        internal_energy;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic [62:0]        rho;
        logic [63:0]        diff;
        logic               ecnd;
        logic [16:0]        dmg;
        logic signed [63:0] tr;
        logic               vact;
        logic [63:0]        sq;
        logic signed [63:0] mu;
        logic signed [63:0] den;
        logic signed [63:0] p;
        logic signed [63:0] acc;
        logic [62:0]        e;
        logic               sat;
    } ctx_t;

    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } sat_res_t;

    function automatic logic [63:0] mag(logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic sat_res_t apply_sign(logic neg, logic [63:0] m, logic big);
        sat_res_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (big || m > S64_MIN) begin
                r.sat = 1'b1;
                r.val = S64_MIN;
            end else begin
                r.val = 64'd0 - m;
            end
        end else if (big || m[63]) begin
            r.sat = 1'b1;
            r.val = S64_MAX;
        end else begin
            r.val = m;
        end
        return r;
    endfunction

    function automatic sat_res_t fx_add(logic [63:0] a, logic [63:0] b);
        sat_res_t r;
        r.val = a + b;
        r.sat = (a[63] == b[63]) && (r.val[63] != a[63]);
        if (r.sat) begin
            r.val = a[63] ? S64_MIN : S64_MAX;
        end
        return r;
    endfunction

    function automatic sat_res_t fx_sub(logic [63:0] a, logic [63:0] b);
        sat_res_t r;
        r.val = a - b;
        r.sat = (a[63] != b[63]) && (r.val[63] != a[63]);
        if (r.sat) begin
            r.val = a[63] ? S64_MIN : S64_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/sep_mul.sv =====
// Pipelined saturating fixed-point multiplier on sign and magnitude operands.
module sep_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [63:0]      a_mag,
    input  logic [63:0]      b_mag,
    input  logic             a_neg,
    input  logic             b_neg,
    input  sep_pkg::ctx_t    tag_in,
    output logic             out_valid,
    output logic [63:0]      res,
    output logic             sat,
    output sep_pkg::ctx_t    tag_out
);

    logic [2:0]          v_reg;
    logic [63:0]         a_reg;
    logic [63:0]         b_reg;
    logic [2:0]          neg_reg;
    sep_pkg::ctx_t       tag_reg [0:2];
    logic [63:0]         p0_reg;
    logic [63:0]         p1_reg;
    logic [63:0]         p2_reg;
    logic [63:0]         p3_reg;
    logic [63:0]         lo_reg;
    logic [63:0]         hsum_reg;
    logic [1:0]          midc_reg;
    logic [33:0]         mid_next;
    logic [63:0]         hi_next;
    logic [127:0]        full_next;
    sep_pkg::sat_res_t   fin_next;
    logic                out_valid_reg;
    logic [63:0]         res_reg;
    logic                sat_reg;
    sep_pkg::ctx_t       tag_out_reg;

    always_comb
    begin
        mid_next  = 34'(p0_reg[63:32]) + 34'(p1_reg[31:0]) + 34'(p2_reg[31:0]);
        hi_next   = hsum_reg + 64'(midc_reg);
        full_next = {hi_next, lo_reg};
        fin_next  = sep_pkg::apply_sign(neg_reg[2], full_next[sep_pkg::FRAC_BITS +: 64],
                                        (hi_next >> sep_pkg::FRAC_BITS) != 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg         <= {v_reg[1:0], in_valid};
            out_valid_reg <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_mag;
        b_reg       <= b_mag;
        neg_reg     <= {neg_reg[1:0], a_neg ^ b_neg};
        tag_reg[0]  <= tag_in;
        tag_reg[1]  <= tag_reg[0];
        tag_reg[2]  <= tag_reg[1];
        p0_reg      <= 64'(a_reg[31:0])  * 64'(b_reg[31:0]);
        p1_reg      <= 64'(a_reg[31:0])  * 64'(b_reg[63:32]);
        p2_reg      <= 64'(a_reg[63:32]) * 64'(b_reg[31:0]);
        p3_reg      <= 64'(a_reg[63:32]) * 64'(b_reg[63:32]);
        lo_reg      <= {mid_next[31:0], p0_reg[31:0]};
        midc_reg    <= mid_next[33:32];
        hsum_reg    <= p3_reg + 64'(p1_reg[63:32]) + 64'(p2_reg[63:32]);
        res_reg     <= fin_next.val;
        sat_reg     <= fin_next.sat;
        tag_out_reg <= tag_reg[2];
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign sat       = sat_reg;
    assign tag_out   = tag_out_reg;

endmodule

// ===== rtl/sep_div.sv =====
// Pipelined restoring fixed-point divider, one quotient bit per stage.
module sep_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [63:0]      a_mag,
    input  logic [63:0]      b_mag,
    input  logic             a_neg,
    input  logic             b_neg,
    input  sep_pkg::ctx_t    tag_in,
    output logic             out_valid,
    output logic [63:0]      res,
    output logic             sat,
    output sep_pkg::ctx_t    tag_out
);

    localparam int N = sep_pkg::DIV_STEPS;

    logic            v_reg   [0:N];
    logic [63:0]     rem_reg [0:N];
    logic [127:0]    num_reg [0:N];
    logic [63:0]     q_reg   [0:N];
    logic            big_reg [0:N];
    logic [63:0]     den_reg [0:N];
    logic            an_reg  [0:N];
    logic            neg_reg [0:N];
    sep_pkg::ctx_t   tag_reg [0:N];

    sep_pkg::sat_res_t fin_next;
    logic              out_valid_reg;
    logic [63:0]       res_reg;
    logic              sat_reg;
    sep_pkg::ctx_t     tag_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        num_reg[0] <= 128'(a_mag) << sep_pkg::FRAC_BITS;
        q_reg[0]   <= '0;
        big_reg[0] <= 1'b0;
        den_reg[0] <= b_mag;
        an_reg[0]  <= a_neg;
        neg_reg[0] <= a_neg ^ b_neg;
        tag_reg[0] <= tag_in;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [64:0] rs_next;
        logic        ge_next;
        logic [64:0] rem_next;

        always_comb
        begin
            rs_next  = {rem_reg[k], num_reg[k][127]};
            ge_next  = rs_next >= {1'b0, den_reg[k]};
            rem_next = ge_next ? rs_next - {1'b0, den_reg[k]} : rs_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next[63:0];
            num_reg[k+1] <= num_reg[k] << 1;
            q_reg[k+1]   <= {q_reg[k][62:0], ge_next};
            big_reg[k+1] <= big_reg[k] | q_reg[k][63];
            den_reg[k+1] <= den_reg[k];
            an_reg[k+1]  <= an_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            tag_reg[k+1] <= tag_reg[k];
        end
    end

    always_comb
    begin
        if (den_reg[N] == 64'd0)
        begin
            fin_next.sat = 1'b1;
            fin_next.val = an_reg[N] ? sep_pkg::S64_MIN : sep_pkg::S64_MAX;
        end
        else
        begin
            fin_next = sep_pkg::apply_sign(neg_reg[N], q_reg[N], big_reg[N]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= fin_next.val;
        sat_reg     <= fin_next.sat;
        tag_out_reg <= tag_reg[N];
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign sat       = sat_reg;
    assign tag_out   = tag_out_reg;

endmodule

// ===== rtl/shock_eos_pressure.sv =====
// Top level of the Mie-Gruneisen shock pressure pipeline.
// The result strobes on done for each accepted start transaction.
// Throughput: one particle per cycle; busy stays low and the pipeline never stalls.
// The latency is set by the 64-stage square root, three 130-stage dividers
// and twelve 4-stage multipliers in series.
// Reset clears all valid bits and loads the register defaults (reference density 1.0).
module shock_eos_pressure (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sep_pkg::in_t                      item,
    output logic                              done,
    output sep_pkg::out_t                     result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sep_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data
);

    localparam int NS = sep_pkg::SQRT_STEPS;
    localparam int NO = sep_pkg::NUM_OPS;

    logic [62:0]        ref_density_reg;
    logic [62:0]        sound_speed_reg;
    logic signed [63:0] hugoniot_slope_reg;
    logic signed [63:0] gruneisen_gamma_reg;
    logic signed [63:0] ref_temperature_reg;
    logic [62:0]        heat_coeff_reg;
    logic signed [63:0] visc_quad_coeff_reg;
    logic signed [63:0] visc_lin_coeff_reg;

    logic               in_v_reg;
    sep_pkg::in_t       item_reg;

    logic               sq_v_reg    [0:NS-1];
    logic [67:0]        sq_rem_reg  [0:NS-1];
    logic [63:0]        sq_root_reg [0:NS-1];
    logic [127:0]       sq_n_reg    [0:NS-1];
    sep_pkg::ctx_t      sq_ctx_reg  [0:NS-1];
    logic               sq_v_in     [0:NS-1];
    logic [67:0]        sq_rem_in   [0:NS-1];
    logic [63:0]        sq_root_in  [0:NS-1];
    logic [127:0]       sq_n_in     [0:NS-1];
    sep_pkg::ctx_t      sq_ctx_in   [0:NS-1];
    sep_pkg::ctx_t      entry_ctx;
    logic [127:0]       entry_n;

    logic               op_valid [0:NO-1];
    logic [63:0]        op_a     [0:NO-1];
    logic [63:0]        op_b     [0:NO-1];
    logic               op_an    [0:NO-1];
    logic               op_bn    [0:NO-1];
    sep_pkg::ctx_t      op_tag   [0:NO-1];
    logic               res_valid [0:NO-1];
    logic [63:0]        res_val   [0:NO-1];
    logic               res_sat   [0:NO-1];
    sep_pkg::ctx_t      res_tag   [0:NO-1];

    sep_pkg::ctx_t      fin_ctx;
    logic               done_reg;
    sep_pkg::out_t      result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_density_reg     <= sep_pkg::FX_ONE[62:0];
            sound_speed_reg     <= '0;
            hugoniot_slope_reg  <= '0;
            gruneisen_gamma_reg <= '0;
            ref_temperature_reg <= '0;
            heat_coeff_reg      <= '0;
            visc_quad_coeff_reg <= '0;
            visc_lin_coeff_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sep_pkg::REG_REF_DENSITY: ref_density_reg     <= cfg_data[62:0];
                sep_pkg::REG_SOUND_SPEED: sound_speed_reg     <= cfg_data[62:0];
                sep_pkg::REG_HUG_SLOPE:   hugoniot_slope_reg  <= cfg_data;
                sep_pkg::REG_GAMMA:       gruneisen_gamma_reg <= cfg_data;
                sep_pkg::REG_REF_TEMP:    ref_temperature_reg <= cfg_data;
                sep_pkg::REG_HEAT_COEFF:  heat_coeff_reg      <= cfg_data[62:0];
                sep_pkg::REG_VISC_QUAD:   visc_quad_coeff_reg <= cfg_data;
                sep_pkg::REG_VISC_LIN:    visc_lin_coeff_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item;
    end

    always_comb
    begin
        sep_pkg::sat_res_t t1;
        sep_pkg::sat_res_t t2;
        logic              visc;
        t1   = sep_pkg::fx_add(item_reg.rate_xx, item_reg.rate_yy);
        t2   = sep_pkg::fx_add(t1.val, item_reg.rate_zz);
        visc = (visc_quad_coeff_reg != 64'sd0) || (visc_lin_coeff_reg != 64'sd0);
        entry_ctx      = '0;
        entry_ctx.rho  = item_reg.density;
        entry_ctx.diff = item_reg.temperature - ref_temperature_reg;
        entry_ctx.ecnd = (heat_coeff_reg != 63'd0)
                         && (item_reg.temperature > ref_temperature_reg);
        entry_ctx.dmg  = item_reg.damage;
        entry_ctx.tr   = t2.val;
        entry_ctx.vact = visc && t2.val[63];
        entry_ctx.sat  = visc && (t1.sat || t2.sat);
        entry_n        = 128'(item_reg.volume_ratio) << sep_pkg::FRAC_BITS;
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        logic [67:0] rs_next;
        logic [67:0] trial_next;
        logic        ge_next;

        if (k == 0)
        begin : g_first
            assign sq_v_in[k]    = in_v_reg;
            assign sq_rem_in[k]  = '0;
            assign sq_root_in[k] = '0;
            assign sq_n_in[k]    = entry_n;
            assign sq_ctx_in[k]  = entry_ctx;
        end
        else
        begin : g_next
            assign sq_v_in[k]    = sq_v_reg[k-1];
            assign sq_rem_in[k]  = sq_rem_reg[k-1];
            assign sq_root_in[k] = sq_root_reg[k-1];
            assign sq_n_in[k]    = sq_n_reg[k-1];
            assign sq_ctx_in[k]  = sq_ctx_reg[k-1];
        end

        always_comb
        begin
            rs_next    = {sq_rem_in[k][65:0], sq_n_in[k][127:126]};
            trial_next = {2'b00, sq_root_in[k], 2'b01};
            ge_next    = rs_next >= trial_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else
            begin
                sq_v_reg[k] <= sq_v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_rem_reg[k]  <= ge_next ? rs_next - trial_next : rs_next;
            sq_root_reg[k] <= {sq_root_in[k][62:0], ge_next};
            sq_n_reg[k]    <= sq_n_in[k] << 2;
            sq_ctx_reg[k]  <= sq_ctx_in[k];
        end
    end

    always_comb
    begin
        sep_pkg::ctx_t     c;
        sep_pkg::sat_res_t r1;
        sep_pkg::sat_res_t r2;
        logic [63:0]       frac;

        op_valid[0] = sq_v_reg[NS-1];
        for (int k = 1; k < NO; k++)
        begin
            op_valid[k] = res_valid[k-1];
        end

        c        = sq_ctx_reg[NS-1];
        c.sq     = sq_root_reg[NS-1];
        op_a[0]  = {1'b0, c.rho};
        op_b[0]  = {1'b0, ref_density_reg};
        op_an[0] = 1'b0;
        op_bn[0] = 1'b0;
        op_tag[0] = c;

        c        = res_tag[0];
        r1       = sep_pkg::fx_sub(res_val[0], sep_pkg::FX_ONE);
        r2       = sep_pkg::fx_sub(hugoniot_slope_reg, sep_pkg::FX_ONE);
        c.mu     = r1.val;
        c.sat    = c.sat | res_sat[0] | r1.sat | r2.sat;
        op_a[1]  = sep_pkg::mag(r2.val);
        op_an[1] = r2.val[63];
        op_b[1]  = sep_pkg::mag(c.mu);
        op_bn[1] = c.mu[63];
        op_tag[1] = c;

        c        = res_tag[1];
        r1       = sep_pkg::fx_sub(sep_pkg::FX_ONE, res_val[1]);
        c.den    = r1.val;
        c.sat    = c.sat | res_sat[1] | r1.sat;
        op_a[2]  = {1'b0, ref_density_reg};
        op_an[2] = 1'b0;
        op_b[2]  = {1'b0, sound_speed_reg};
        op_bn[2] = 1'b0;
        op_tag[2] = c;

        c        = res_tag[2];
        c.sat    = c.sat | res_sat[2];
        op_a[3]  = sep_pkg::mag(res_val[2]);
        op_an[3] = res_val[2][63];
        op_b[3]  = {1'b0, sound_speed_reg};
        op_bn[3] = 1'b0;
        op_tag[3] = c;

        c        = res_tag[3];
        c.sat    = c.sat | res_sat[3];
        op_a[4]  = sep_pkg::mag(res_val[3]);
        op_an[4] = res_val[3][63];
        op_b[4]  = sep_pkg::mag(c.mu);
        op_bn[4] = c.mu[63];
        op_tag[4] = c;

        c        = res_tag[4];
        r1       = sep_pkg::fx_add(sep_pkg::FX_ONE, c.mu);
        c.sat    = c.sat | res_sat[4] | r1.sat;
        op_a[5]  = sep_pkg::mag(res_val[4]);
        op_an[5] = res_val[4][63];
        op_b[5]  = sep_pkg::mag(r1.val);
        op_bn[5] = r1.val[63];
        op_tag[5] = c;

        c        = res_tag[5];
        c.sat    = c.sat | res_sat[5];
        op_a[6]  = sep_pkg::mag(res_val[5]);
        op_an[6] = res_val[5][63];
        op_b[6]  = sep_pkg::mag(c.den);
        op_bn[6] = c.den[63];
        op_tag[6] = c;

        c        = res_tag[6];
        c.sat    = c.sat | res_sat[6];
        op_a[7]  = sep_pkg::mag(res_val[6]);
        op_an[7] = res_val[6][63];
        op_b[7]  = sep_pkg::mag(c.den);
        op_bn[7] = c.den[63];
        op_tag[7] = c;

        c        = res_tag[7];
        c.sat    = c.sat | res_sat[7];
        c.p      = res_val[7];
        op_a[8]  = {1'b0, heat_coeff_reg};
        op_an[8] = 1'b0;
        op_b[8]  = c.diff;
        op_bn[8] = 1'b0;
        op_tag[8] = c;

        c        = res_tag[8];
        if (c.ecnd)
        begin
            c.e   = res_val[8][62:0];
            c.sat = c.sat | res_sat[8];
        end
        else
        begin
            c.e = '0;
        end
        op_a[9]  = sep_pkg::mag(gruneisen_gamma_reg);
        op_an[9] = gruneisen_gamma_reg[63];
        op_b[9]  = {1'b0, c.e};
        op_bn[9] = 1'b0;
        op_tag[9] = c;

        c        = res_tag[9];
        r1       = sep_pkg::fx_add(c.p, res_val[9]);
        c.p      = r1.val;
        c.sat    = c.sat | res_sat[9] | r1.sat;
        frac     = 64'(sep_pkg::DMG_ONE - c.dmg) << (sep_pkg::FRAC_BITS - 16);
        op_a[10]  = sep_pkg::mag(c.p);
        op_an[10] = c.p[63];
        op_b[10]  = frac;
        op_bn[10] = 1'b0;
        op_tag[10] = c;

        c        = res_tag[10];
        if (c.dmg != 17'd0 && c.p[63])
        begin
            if (c.dmg >= sep_pkg::DMG_ONE)
            begin
                c.p = '0;
            end
            else
            begin
                c.p   = res_val[10];
                c.sat = c.sat | res_sat[10];
            end
        end
        op_a[11]  = sep_pkg::mag(visc_quad_coeff_reg);
        op_an[11] = visc_quad_coeff_reg[63];
        op_b[11]  = sep_pkg::mag(c.tr);
        op_bn[11] = c.tr[63];
        op_tag[11] = c;

        c        = res_tag[11];
        c.acc    = res_val[11];
        c.sat    = c.sat | (c.vact & res_sat[11]);
        op_a[12]  = sep_pkg::mag(visc_lin_coeff_reg);
        op_an[12] = visc_lin_coeff_reg[63];
        op_b[12]  = c.sq;
        op_bn[12] = 1'b0;
        op_tag[12] = c;

        c        = res_tag[12];
        r1       = sep_pkg::fx_sub(c.acc, res_val[12]);
        c.acc    = r1.val;
        c.sat    = c.sat | (c.vact & (res_sat[12] | r1.sat));
        op_a[13]  = {1'b0, c.rho};
        op_an[13] = 1'b0;
        op_b[13]  = sep_pkg::mag(c.tr);
        op_bn[13] = c.tr[63];
        op_tag[13] = c;

        c        = res_tag[13];
        c.sat    = c.sat | (c.vact & res_sat[13]);
        op_a[14]  = sep_pkg::mag(res_val[13]);
        op_an[14] = res_val[13][63];
        op_b[14]  = sep_pkg::mag(c.acc);
        op_bn[14] = c.acc[63];
        op_tag[14] = c;

        c = res_tag[14];
        if (c.vact)
        begin
            r1    = sep_pkg::fx_add(c.p, res_val[14]);
            c.p   = r1.val;
            c.sat = c.sat | res_sat[14] | r1.sat;
        end
        fin_ctx = c;
    end

    for (genvar k = 0; k < NO; k++)
    begin : g_op
        if (sep_pkg::OP_IS_DIV[k])
        begin : g_div
            sep_div u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (op_valid[k]),
                .a_mag     (op_a[k]),
                .b_mag     (op_b[k]),
                .a_neg     (op_an[k]),
                .b_neg     (op_bn[k]),
                .tag_in    (op_tag[k]),
                .out_valid (res_valid[k]),
                .res       (res_val[k]),
                .sat       (res_sat[k]),
                .tag_out   (res_tag[k])
            );
        end
        else
        begin : g_mul
            sep_mul u_mul (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (op_valid[k]),
                .a_mag     (op_a[k]),
                .b_mag     (op_b[k]),
                .a_neg     (op_an[k]),
                .b_neg     (op_bn[k]),
                .tag_in    (op_tag[k]),
                .out_valid (res_valid[k]),
                .res       (res_val[k]),
                .sat       (res_sat[k]),
                .tag_out   (res_tag[k])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid[NO-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.pressure        <= fin_ctx.p;
        result_reg.internal_energy <= fin_ctx.e;
        result_reg.saturated       <= fin_ctx.sat;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/sep_chk.sv =====
// Port-level checker for the shock pressure pipeline, bound to the top level.
`include "assert_macros.svh"

module sep_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic                              cfg_ready
);

    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `ASSERT_ALWAYS(a_cfg_always_ready, clk, rst_n, cfg_ready)
    `ASSERT_IMPLY(a_result_follows, clk, rst_n, start && !busy, ##(sep_pkg::LATENCY) done)
    `ASSERT_IMPLY(a_no_spurious, clk, rst_n, !start, ##(sep_pkg::LATENCY) !done)

endmodule

bind shock_eos_pressure sep_chk u_sep_chk (.*);
